// ----- rtl/core/grid_astar_next_step_top_assert.svh -----
// assertion macros for the checker file
`ifndef GRID_ASTAR_NEXT_STEP_TOP_ASSERT_SVH
`define GRID_ASTAR_NEXT_STEP_TOP_ASSERT_SVH

// clocked assertion, off while reset is held
`define GASTAR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define GASTAR_ASSERT_RAW(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/gastar_pkg.sv -----
package gastar_pkg;

    localparam int COORD_W   = 5;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W     = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
    localparam logic [CFG_W-1:0]     DIM_RESET     = 6'd32;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // move directions
    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               is_passable;
        logic [COORD_W-1:0] goal_row;
        logic [COORD_W-1:0] goal_col;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [1:0]       next_direction;
        logic [LEN_W-1:0] path_length;
    } t_out_item;

endpackage

// ----- rtl/core/grid_astar_next_step_top.sv -----
// Grid path finder. A map of passable and wall cells is written one cell per input transfer
// (operation 0, acknowledged by an all-zero result). A query transfer (operation 1) runs an A*
// search with four-neighbour moves, unit step cost and a Manhattan heuristic from the start
// cell to the goal cell, and returns found, the path length and the first move (0 down,
// 1 right, 2 up, 3 left). One item is worked on at a time; the next input transfer is taken
// as soon as the result sits in the output register. A query first clears the open/closed
// store over all N entries, where N = 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) is the depth of
// the cell memories, then pops the heap root and sifts the last entry down level by level,
// tries each neighbour and sifts every push up level by level, and finally traces back
// along the parent directions. The heap memory has a single read port, which every sift
// step uses in turn. After reset the map memory is swept to walls over all N cells, during
// which no input transfer is taken; configuration writes are always taken.
module grid_astar_next_step_top #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  gastar_pkg::t_in_item                  i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output gastar_pkg::t_out_item                 o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gastar_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gastar_pkg::CFG_W-1:0]          i_cfg_data
);
    import gastar_pkg::*;

    // cell index is {row, col}
    localparam int RW         = $clog2(MAX_ROWS);
    localparam int CW         = $clog2(MAX_COLS);
    localparam int CELL_W     = RW + CW;
    localparam int MAP_DEPTH  = 1 << CELL_W;
    localparam int NUM_CELLS  = MAX_ROWS * MAX_COLS;
    localparam int G_W        = CELL_W + 1;
    localparam int F_W        = CELL_W + 2;
    localparam int HI_W       = CELL_W + 2;
    localparam int HEAP_DEPTH = 1 << HI_W;
    localparam int CNT_W      = HI_W + 1;
    localparam int SEQ_W      = HI_W + 1;

    localparam logic [7:0] MAX_R8 = 8'(MAX_ROWS);
    localparam logic [7:0] MAX_C8 = 8'(MAX_COLS);
    // neighbour counter value meaning all four tried
    localparam logic [2:0] NB_DONE = 3'd4;

    typedef struct packed {
        logic [F_W-1:0]    f;
        logic [G_W-1:0]    g;
        logic [SEQ_W-1:0]  seq;
        logic [CELL_W-1:0] loc;
    } t_entry;

    // open cost of zero means not yet reached
    typedef struct packed {
        logic           closed;
        logic [F_W-1:0] cost;
    } t_node;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_QCHK, S_QMS, S_QMG, S_CLR, S_SEED,
        S_PU_UP, S_PU_CMP, S_NB_RD, S_NB_CHK,
        S_PO_TOP, S_PO_LAST, S_PO_GETL, S_PO_LOOP, S_PO_RR, S_PO_DEC, S_PO_FIN,
        S_CLS_CHK, S_TR_RD, S_TR_USE, S_DONE
    } t_state;

    // heap order: lower f, then larger g, then earlier push
    function automatic logic goes_first(input t_entry a, input t_entry b);
        if (a.f != b.f) return a.f < b.f;
        if (a.g != b.g) return a.g > b.g;
        return a.seq < b.seq;
    endfunction

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // one move from a cell, with its bound check; returns {ok, new cell}
    function automatic logic [CELL_W:0] step_cell(input logic [CELL_W-1:0] pos,
                                                  input logic [1:0] d,
                                                  input logic [7:0] rlim,
                                                  input logic [7:0] clim);
        logic [RW-1:0] r;
        logic [CW-1:0] c;
        logic          ok;
        r  = pos[CELL_W-1:CW];
        c  = pos[CW-1:0];
        ok = 1'b0;
        case (d)
            DIR_DOWN: begin
                ok = (8'(r) + 8'd1) < rlim;
                r  = r + RW'(1);
            end
            DIR_RIGHT: begin
                ok = (8'(c) + 8'd1) < clim;
                c  = c + CW'(1);
            end
            DIR_UP: begin
                ok = (r != '0);
                r  = r - RW'(1);
            end
            DIR_LEFT: begin
                ok = (c != '0);
                c  = c - CW'(1);
            end
            default: ok = 1'b0;
        endcase
        return {ok, r, c};
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [G_W-1:0] g);
        return (32'(g) > 32'(LEN_MAX)) ? LEN_MAX : LEN_W'(g);
    endfunction

    // control and working registers
    t_state             r_state, n_state;
    logic [CELL_W-1:0]  r_sweep, n_sweep;
    logic [CFG_W-1:0]   r_rows, r_cols;
    logic [COORD_W-1:0] r_sr, r_sc, r_gr, r_gc, n_sr, n_sc, n_gr, n_gc;
    t_entry             r_top, n_top, r_last, n_last, r_lc, n_lc, r_pe, n_pe;
    logic               r_has_r, n_has_r;
    logic [HI_W-1:0]    r_i, n_i, r_pi, n_pi;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic [2:0]         r_k, n_k;
    logic [CELL_W-1:0]  r_n, n_n, r_cur, n_cur;
    logic [F_W-1:0]     r_nf, n_nf;
    logic [1:0]         r_dir, n_dir;
    logic [CELL_W:0]    r_guard, n_guard;
    t_out_item          r_res, n_res, r_out, n_out;
    logic               r_out_valid, n_out_valid;

    // memory ports
    logic              map_we, map_wd, r_map_rd;
    logic [CELL_W-1:0] map_wa, map_ra;
    logic              node_we;
    t_node             node_wd, r_node_rd;
    logic [CELL_W-1:0] node_wa, node_ra;
    logic              par_we;
    logic [1:0]        par_wd, r_par_rd;
    logic [CELL_W-1:0] par_wa, par_ra;
    logic              heap_we;
    t_entry            heap_wd, r_heap_rd;
    logic [HI_W-1:0]   heap_wa, heap_ra;

    logic              r_map_mem  [MAP_DEPTH];
    t_node             r_node_mem [MAP_DEPTH];
    logic [1:0]        r_par_mem  [MAP_DEPTH];
    t_entry            r_heap_mem [HEAP_DEPTH];

    // derived values
    logic [7:0]        rows_eff, cols_eff;
    logic [CELL_W-1:0] start_cell, goal_cell, in_cell;
    logic [7:0]        h0;
    logic [CELL_W:0]   nb_step, tr_step;
    logic [7:0]        nb_dr, nb_dc;
    logic [HI_W:0]     lidx;
    logic [HI_W+1:0]   ridx;
    logic [HI_W-1:0]   pu_up;
    logic              use_r;
    t_entry            best;
    logic [HI_W-1:0]   best_idx;
    logic              q_range_ok, w_range_ok;

    // register values of zero or above the maximum are clamped
    assign rows_eff = (r_rows == '0) ? 8'd1 : ((8'(r_rows) > MAX_R8) ? MAX_R8 : 8'(r_rows));
    assign cols_eff = (r_cols == '0) ? 8'd1 : ((8'(r_cols) > MAX_C8) ? MAX_C8 : 8'(r_cols));

    assign start_cell = {RW'(r_sr), CW'(r_sc)};
    assign goal_cell  = {RW'(r_gr), CW'(r_gc)};
    assign in_cell    = {RW'(i_in_data.cell_row), CW'(i_in_data.cell_col)};
    assign h0         = absdiff8(8'(r_sr), 8'(r_gr)) + absdiff8(8'(r_sc), 8'(r_gc));

    assign q_range_ok = (8'(r_sr) < rows_eff) && (8'(r_sc) < cols_eff)
                     && (8'(r_gr) < rows_eff) && (8'(r_gc) < cols_eff);
    assign w_range_ok = (8'(i_in_data.cell_row) < MAX_R8) && (8'(i_in_data.cell_col) < MAX_C8);

    // neighbour of the expanded cell and its heuristic
    assign nb_step = step_cell(r_top.loc, r_k[1:0], rows_eff, cols_eff);
    assign nb_dr   = absdiff8(8'(nb_step[CELL_W-1:CW]), 8'(r_gr));
    assign nb_dc   = absdiff8(8'(nb_step[CW-1:0]), 8'(r_gc));

    // trace-back move over the whole store
    assign tr_step = step_cell(r_cur, r_par_rd, MAX_R8, MAX_C8);

    // heap addressing
    assign lidx     = {r_i, 1'b1};
    assign ridx     = {1'b0, lidx} + (HI_W+2)'(1);
    assign pu_up    = (r_pi - HI_W'(1)) >> 1;
    assign use_r    = r_has_r && goes_first(r_heap_rd, r_lc);
    assign best     = use_r ? r_heap_rd : r_lc;
    assign best_idx = use_r ? HI_W'(ridx) : HI_W'(lidx);

    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_sr        = r_sr;
        n_sc        = r_sc;
        n_gr        = r_gr;
        n_gc        = r_gc;
        n_top       = r_top;
        n_last      = r_last;
        n_lc        = r_lc;
        n_pe        = r_pe;
        n_has_r     = r_has_r;
        n_i         = r_i;
        n_pi        = r_pi;
        n_count     = r_count;
        n_seq       = r_seq;
        n_k         = r_k;
        n_n         = r_n;
        n_cur       = r_cur;
        n_nf        = r_nf;
        n_dir       = r_dir;
        n_guard     = r_guard;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        map_we  = 1'b0;
        map_wa  = r_sweep;
        map_wd  = 1'b0;
        map_ra  = start_cell;
        node_we = 1'b0;
        node_wa = r_n;
        node_wd = '0;
        node_ra = r_n;
        par_we  = 1'b0;
        par_wa  = r_n;
        par_wd  = r_k[1:0] + 2'd2;
        par_ra  = r_cur;
        heap_we = 1'b0;
        heap_wa = r_pi;
        heap_wd = r_pe;
        heap_ra = '0;

        // output register empties on its transfer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // map sweep to walls after reset
            S_INIT: begin
                map_we  = 1'b1;
                map_wa  = r_sweep;
                n_sweep = r_sweep + CELL_W'(1);
                if (&r_sweep) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res = '0;
                    if (i_in_data.operation == OP_WRITE) begin
                        map_we  = w_range_ok;
                        map_wa  = in_cell;
                        map_wd  = i_in_data.is_passable;
                        n_state = S_DONE;
                    end else begin
                        n_sr    = i_in_data.cell_row;
                        n_sc    = i_in_data.cell_col;
                        n_gr    = i_in_data.goal_row;
                        n_gc    = i_in_data.goal_col;
                        n_state = S_QCHK;
                    end
                end
            end
            S_QCHK: begin
                map_ra  = start_cell;
                n_state = q_range_ok ? S_QMS : S_DONE;
            end
            S_QMS: begin
                map_ra  = goal_cell;
                n_state = r_map_rd ? S_QMG : S_DONE;
            end
            S_QMG: begin
                n_sweep = '0;
                n_state = r_map_rd ? S_CLR : S_DONE;
            end
            // open costs and closed marks cleared for this query
            S_CLR: begin
                node_we = 1'b1;
                node_wa = r_sweep;
                node_wd = '0;
                n_sweep = r_sweep + CELL_W'(1);
                if (&r_sweep) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                node_we = 1'b1;
                node_wa = start_cell;
                node_wd = '{closed: 1'b0, cost: F_W'(h0)};
                n_pe    = '{f: F_W'(h0), g: '0, seq: '0, loc: start_cell};
                n_seq   = SEQ_W'(1);
                n_count = CNT_W'(1);
                n_pi    = '0;
                n_k     = NB_DONE;
                n_state = S_PU_UP;
            end
            // sift-up: each heap level is read in S_PU_UP and compared and written in S_PU_CMP
            S_PU_UP: begin
                if (r_pi == '0) begin
                    heap_we = 1'b1;
                    heap_wa = '0;
                    heap_wd = r_pe;
                    n_state = S_NB_RD;
                end else begin
                    heap_ra = pu_up;
                    n_state = S_PU_CMP;
                end
            end
            S_PU_CMP: begin
                heap_we = 1'b1;
                heap_wa = r_pi;
                if (goes_first(r_pe, r_heap_rd)) begin
                    heap_wd = r_heap_rd;
                    n_pi    = pu_up;
                    n_state = S_PU_UP;
                end else begin
                    heap_wd = r_pe;
                    n_state = S_NB_RD;
                end
            end
            // neighbours tried down, right, up, left
            S_NB_RD: begin
                if (r_k == NB_DONE) begin
                    n_state = S_PO_TOP;
                end else if (!nb_step[CELL_W]) begin
                    n_k = r_k + 3'd1;
                end else begin
                    map_ra  = nb_step[CELL_W-1:0];
                    node_ra = nb_step[CELL_W-1:0];
                    n_n     = nb_step[CELL_W-1:0];
                    n_nf    = F_W'(r_top.g) + F_W'(1) + F_W'(nb_dr) + F_W'(nb_dc);
                    n_state = S_NB_CHK;
                end
            end
            S_NB_CHK: begin
                n_k     = r_k + 3'd1;
                n_state = S_NB_RD;
                if (r_map_rd && !r_node_rd.closed
                    && (r_node_rd.cost == '0 || r_node_rd.cost > r_nf)) begin
                    node_we = 1'b1;
                    node_wa = r_n;
                    node_wd = '{closed: 1'b0, cost: r_nf};
                    par_we  = 1'b1;
                    par_wa  = r_n;
                    par_wd  = r_k[1:0] + 2'd2;
                    if (r_count < CNT_W'(HEAP_DEPTH)) begin
                        n_pe    = '{f: r_nf, g: r_top.g + G_W'(1), seq: r_seq, loc: r_n};
                        n_seq   = r_seq + SEQ_W'(1);
                        n_pi    = HI_W'(r_count);
                        n_count = r_count + CNT_W'(1);
                        n_state = S_PU_UP;
                    end
                end
            end
            // pop: take the root, move the last entry down
            S_PO_TOP: begin
                if (r_count == '0) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    heap_ra = '0;
                    n_state = S_PO_LAST;
                end
            end
            S_PO_LAST: begin
                n_top   = r_heap_rd;
                heap_ra = HI_W'(r_count - CNT_W'(1));
                n_count = r_count - CNT_W'(1);
                n_state = S_PO_GETL;
            end
            S_PO_GETL: begin
                n_last  = r_heap_rd;
                n_i     = '0;
                n_state = S_PO_LOOP;
            end
            S_PO_LOOP: begin
                if (lidx >= r_count) begin
                    n_state = S_PO_FIN;
                end else begin
                    heap_ra = HI_W'(lidx);
                    n_state = S_PO_RR;
                end
            end
            S_PO_RR: begin
                n_lc    = r_heap_rd;
                n_has_r = ridx < (HI_W+2)'(r_count);
                heap_ra = HI_W'(ridx);
                n_state = S_PO_DEC;
            end
            S_PO_DEC: begin
                if (!goes_first(best, r_last)) begin
                    n_state = S_PO_FIN;
                end else begin
                    heap_we = 1'b1;
                    heap_wa = r_i;
                    heap_wd = best;
                    n_i     = best_idx;
                    n_state = S_PO_LOOP;
                end
            end
            S_PO_FIN: begin
                heap_we = (r_count != '0);
                heap_wa = r_i;
                heap_wd = r_last;
                node_ra = r_top.loc;
                n_state = S_CLS_CHK;
            end
            // stale entries of closed cells are dropped
            S_CLS_CHK: begin
                if (r_node_rd.closed) begin
                    n_state = S_PO_TOP;
                end else begin
                    node_we = 1'b1;
                    node_wa = r_top.loc;
                    node_wd = '{closed: 1'b1, cost: '0};
                    if (r_top.loc == goal_cell) begin
                        n_cur   = goal_cell;
                        n_dir   = DIR_DOWN;
                        n_guard = '0;
                        n_state = S_TR_RD;
                    end else begin
                        n_k     = '0;
                        n_state = S_NB_RD;
                    end
                end
            end
            // walk parent directions back to the start
            S_TR_RD: begin
                if (r_cur == start_cell || r_guard >= (CELL_W+1)'(NUM_CELLS)) begin
                    n_res   = '{found: 1'b1, next_direction: r_dir,
                                path_length: sat_len(r_top.g)};
                    n_state = S_DONE;
                end else begin
                    par_ra  = r_cur;
                    n_state = S_TR_USE;
                end
            end
            S_TR_USE: begin
                n_dir = r_par_rd + 2'd2;
                if (!tr_step[CELL_W]) begin
                    n_res   = '{found: 1'b1, next_direction: r_par_rd + 2'd2,
                                path_length: sat_len(r_top.g)};
                    n_state = S_DONE;
                end else begin
                    n_cur   = tr_step[CELL_W-1:0];
                    n_guard = r_guard + (CELL_W+1)'(1);
                    n_state = S_TR_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_rows      <= DIM_RESET;
            r_cols      <= DIM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GRID_ROWS: r_rows <= i_cfg_data;
                    CFG_GRID_COLS: r_cols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_sr    <= n_sr;
        r_sc    <= n_sc;
        r_gr    <= n_gr;
        r_gc    <= n_gc;
        r_top   <= n_top;
        r_last  <= n_last;
        r_lc    <= n_lc;
        r_pe    <= n_pe;
        r_has_r <= n_has_r;
        r_i     <= n_i;
        r_pi    <= n_pi;
        r_count <= n_count;
        r_seq   <= n_seq;
        r_k     <= n_k;
        r_n     <= n_n;
        r_cur   <= n_cur;
        r_nf    <= n_nf;
        r_dir   <= n_dir;
        r_guard <= n_guard;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // cell map
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_wa] <= map_wd;
        end
        r_map_rd <= r_map_mem[map_ra];
    end

    // open cost and closed mark per cell
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_wa] <= node_wd;
        end
        r_node_rd <= r_node_mem[node_ra];
    end

    // direction back to the parent cell
    always_ff @(posedge i_clk) begin
        if (par_we) begin
            r_par_mem[par_wa] <= par_wd;
        end
        r_par_rd <= r_par_mem[par_ra];
    end

    // open heap
    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            r_heap_mem[heap_wa] <= heap_wd;
        end
        r_heap_rd <= r_heap_mem[heap_ra];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- rtl/core/grid_astar_next_step_top_chk.sv -----
`include "grid_astar_next_step_top_assert.svh"

module grid_astar_next_step_top_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input gastar_pkg::t_out_item o_out_data
);
    import gastar_pkg::*;

    // a held result stays offered
    `GASTAR_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")

    // no path means an all-zero result
    `GASTAR_ASSERT(a_miss_zero, o_out_valid && !o_out_data.found |-> o_out_data.next_direction == DIR_DOWN && o_out_data.path_length == '0, "non-zero fields without a path")

    // a zero-length path has no first move
    `GASTAR_ASSERT(a_same_cell, o_out_valid && o_out_data.found && o_out_data.path_length == '0 |-> o_out_data.next_direction == DIR_DOWN, "move reported for start equal to goal")

    // map sweep after reset blocks input
    `GASTAR_ASSERT_RAW(a_reset_stall, !i_rst_n |=> o_in_stall, "input taken straight after reset")

endmodule

bind grid_astar_next_step_top grid_astar_next_step_top_chk u_chk (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import gastar_pkg::*;

    // quiet cycles allowed before the run is declared hung: a full-size query with a
    // 1k-cell sweep and a heap walk over every cell, plus stall bursts, fits well inside
    localparam int QUIET_LIMIT = 1000000;
    localparam int NCELLS      = 1024;
    localparam int HEAP_SLOTS  = 4 * NCELLS;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      o_cfg_ready;

    grid_astar_next_step_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // route predictor: own copy of map, search store and registers
    // ---------------------------------------------------------------
    typedef struct {
        int unsigned f;
        int unsigned g;
        int unsigned s;
        int unsigned c;
    } t_hent;

    bit          map_pass [NCELLS];
    int unsigned open_f   [NCELLS];
    bit          closed_q [NCELLS];
    logic [1:0]  from_dir [NCELLS];
    t_hent       heap_mem [HEAP_SLOTS];
    int unsigned heap_cnt;
    int unsigned push_seq;
    logic [CFG_W-1:0] rows_reg = DIM_RESET;
    logic [CFG_W-1:0] cols_reg = DIM_RESET;

    t_out_item route_expq[$];
    int        mismatches = 0;
    bit        idle_en    = 1'b1;

    function automatic int unsigned dim_clamp(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        return (v > 32) ? 32 : v;
    endfunction

    function automatic int unsigned abs_gap(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int row_step(int k);
        return (k == DIR_DOWN) ? 1 : (k == DIR_UP) ? -1 : 0;
    endfunction

    function automatic int col_step(int k);
        return (k == DIR_RIGHT) ? 1 : (k == DIR_LEFT) ? -1 : 0;
    endfunction

    // lower F first, then larger G, then earlier push
    function automatic bit pops_first(t_hent a, t_hent b);
        if (a.f != b.f) return a.f < b.f;
        if (a.g != b.g) return a.g > b.g;
        return a.s < b.s;
    endfunction

    function automatic void heap_insert(int unsigned c, int unsigned g, int unsigned f);
        t_hent e;
        int unsigned i, up;
        if (heap_cnt >= HEAP_SLOTS) return;
        e = '{f, g, push_seq, c};
        push_seq++;
        i = heap_cnt;
        heap_cnt++;
        while (i > 0) begin
            up = (i - 1) / 2;
            if (!pops_first(e, heap_mem[up])) break;
            heap_mem[i] = heap_mem[up];
            i = up;
        end
        heap_mem[i] = e;
    endfunction

    function automatic t_hent heap_take();
        t_hent top, last;
        int unsigned i, l, r, best;
        top = heap_mem[0];
        heap_cnt--;
        last = heap_mem[heap_cnt];
        i = 0;
        while (1) begin
            l = 2 * i + 1;
            r = l + 1;
            if (l >= heap_cnt) break;
            best = l;
            if (r < heap_cnt && pops_first(heap_mem[r], heap_mem[l])) best = r;
            if (!pops_first(heap_mem[best], last)) break;
            heap_mem[i] = heap_mem[best];
            i = best;
        end
        if (heap_cnt > 0) heap_mem[i] = last;
        return top;
    endfunction

    function automatic t_out_item predict_route(t_in_item it);
        t_out_item   res;
        int unsigned rows, cols, start, goal, cur, dir, guard, n, g, f, cr, cc, pd;
        int          nr, nc;
        t_hent       e;
        res = '0;
        if (it.operation == OP_WRITE) begin
            map_pass[{it.cell_row, it.cell_col}] = it.is_passable;
            return res;
        end
        rows = dim_clamp(rows_reg);
        cols = dim_clamp(cols_reg);
        if (it.cell_row >= rows || it.cell_col >= cols || it.goal_row >= rows ||
            it.goal_col >= cols) return res;
        start = {it.cell_row, it.cell_col};
        goal  = {it.goal_row, it.goal_col};
        if (!map_pass[start] || !map_pass[goal]) return res;
        for (int i = 0; i < NCELLS; i++) begin
            open_f[i]   = 0;
            closed_q[i] = 1'b0;
        end
        heap_cnt = 0;
        push_seq = 0;
        open_f[start] = abs_gap(it.cell_row, it.goal_row) + abs_gap(it.cell_col, it.goal_col);
        heap_insert(start, 0, open_f[start]);
        while (heap_cnt > 0) begin
            e = heap_take();
            if (closed_q[e.c]) continue;
            closed_q[e.c] = 1'b1;
            open_f[e.c]   = 0;
            cr = e.c / 32;
            cc = e.c % 32;
            if (e.c == goal) begin
                // walk back along parent directions to find the first move
                cur = goal;
                dir = 0;
                guard = 0;
                while (cur != start && guard < NCELLS) begin
                    pd = from_dir[cur];
                    nr = int'(cur / 32) + row_step(pd);
                    nc = int'(cur % 32) + col_step(pd);
                    dir = (pd + 2) & 3;
                    if (nr < 0 || nc < 0 || nr >= 32 || nc >= 32) break;
                    cur = nr * 32 + nc;
                    guard++;
                end
                res.found          = 1'b1;
                res.next_direction = dir[1:0];
                res.path_length    = (e.g > 1023) ? LEN_MAX : e.g[LEN_W-1:0];
                return res;
            end
            for (int k = 0; k < 4; k++) begin
                nr = int'(cr) + row_step(k);
                nc = int'(cc) + col_step(k);
                if (nr < 0 || nc < 0 || nr >= int'(rows) || nc >= int'(cols)) continue;
                n = nr * 32 + nc;
                if (!map_pass[n] || closed_q[n]) continue;
                g = e.g + 1;
                f = g + abs_gap(nr, it.goal_row) + abs_gap(nc, it.goal_col);
                if (open_f[n] == 0 || open_f[n] > f) begin
                    open_f[n]   = f;
                    from_dir[n] = 2'((k + 2) & 3);
                    heap_insert(n, g, f);
                end
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // input side: one item per call, valid left high for the next one
    // ---------------------------------------------------------------
    task automatic push_item(t_in_item it);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        // transfer taken at this edge
        route_expq.push_back(predict_route(it));
    endtask

    task automatic send_write(int r, int c, bit p);
        t_in_item it;
        it = '0;
        it.operation   = OP_WRITE;
        it.cell_row    = COORD_W'(r);
        it.cell_col    = COORD_W'(c);
        it.is_passable = p;
        it.goal_row    = COORD_W'($urandom);
        it.goal_col    = COORD_W'($urandom);
        push_item(it);
    endtask

    task automatic send_query(int sr, int sc, int gr, int gc);
        t_in_item it;
        it = '0;
        it.operation   = OP_QUERY;
        it.cell_row    = COORD_W'(sr);
        it.cell_col    = COORD_W'(sc);
        it.goal_row    = COORD_W'(gr);
        it.goal_col    = COORD_W'(gc);
        it.is_passable = 1'($urandom);
        push_item(it);
    endtask

    // wait until every result is back, then wait on so the block is idle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (route_expq.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_GRID_ROWS) rows_reg = val;
        else if (idx == CFG_GRID_COLS) cols_reg = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // output side: stall bursts and result checking
    // ---------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (route_expq.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", o_out_data);
            end else begin
                exp_r = route_expq.pop_front();
                if (o_out_data.found !== exp_r.found ||
                    o_out_data.next_direction !== exp_r.next_direction ||
                    o_out_data.path_length !== exp_r.path_length) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected found %0d dir %0d len %0d, got %0d %0d %0d",
                                 exp_r.found, exp_r.next_direction, exp_r.path_length,
                                 o_out_data.found, o_out_data.next_direction,
                                 o_out_data.path_length);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 9);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no transfer of any kind
    int quiet = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("grid_astar_next_step_top verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // all walls after reset, corner cells, start equal to goal, unreachable goal
    task automatic test_reset_map();
        send_query(0, 0, 0, 0);
        send_write(31, 31, 1'b1);
        send_write(0, 0, 1'b1);
        send_query(0, 0, 0, 0);
        send_query(31, 31, 31, 31);
        send_query(0, 0, 31, 31);
        drain();
    endtask

    // each first move from the centre of an open 3x3, off-grid goal and a walled goal
    task automatic test_directions();
        write_reg(CFG_GRID_ROWS, 6'd3);
        write_reg(CFG_GRID_COLS, 6'd3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_write(r, c, 1'b1);
        send_query(1, 1, 2, 1);
        send_query(1, 1, 1, 2);
        send_query(1, 1, 0, 1);
        send_query(1, 1, 1, 0);
        send_query(0, 0, 3, 0);
        send_write(2, 2, 1'b0);
        send_query(0, 0, 2, 2);
        send_query(2, 0, 0, 2);
        drain();
    endtask

    // zero counts as one, values past the maximum count as the maximum
    task automatic test_dim_clamp();
        write_reg(CFG_GRID_ROWS, 6'd0);
        write_reg(CFG_GRID_COLS, 6'd63);
        send_query(0, 0, 0, 2);
        send_query(0, 2, 1, 2);
        drain();
    endtask

    // full 32x32 grid with an L-shaped corridor along the top row and down the last column
    task automatic test_long_corridor();
        write_reg(CFG_GRID_ROWS, 6'd63);
        write_reg(CFG_GRID_COLS, 6'd32);
        for (int c = 0; c < 32; c++) send_write(0, c, 1'b1);
        for (int r = 1; r < 8; r++) send_write(r, 31, 1'b1);
        send_query(0, 0, 7, 31);
        send_query(7, 31, 0, 0);
        send_query(4, 31, 0, 16);
        send_query(0, 17, 7, 31);
        send_query(0, 0, 17, 15);
        drain();
    endtask

    // one random map on a small grid, then a batch of queries on it
    task automatic random_round(int n_query);
        logic [CFG_W-1:0] rv, cv;
        int rows, cols;
        rv = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 7));
        cv = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 7));
        // keep the searched area small even when a count is clamped up
        if (rv > 32) cv = 6'($urandom_range(1, 3));
        if (cv > 32) rv = 6'($urandom_range(1, 3));
        write_reg(CFG_GRID_ROWS, rv);
        write_reg(CFG_GRID_COLS, cv);
        rows = dim_clamp(rv);
        cols = dim_clamp(cv);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                send_write(r, c, $urandom_range(0, 3) != 0);
        // a stray write anywhere in the store
        send_write($urandom_range(0, 31), $urandom_range(0, 31), 1'($urandom));
        for (int q = 0; q < n_query; q++) begin
            if ($urandom_range(0, 4) != 0)
                send_query($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                           $urandom_range(0, rows - 1), $urandom_range(0, cols - 1));
            else
                send_query($urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 31), $urandom_range(0, 31));
        end
        drain();
    endtask

    task automatic test_random();
        random_round(8);
    endtask

    // back-to-back transfers with no idling on either side
    task automatic test_no_idle();
        idle_en = 1'b0;
        random_round(8);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_map();
        test_directions();
        test_dim_clamp();
        test_long_corridor();
        test_random();
        test_no_idle();
        if (mismatches == 0 && route_expq.size() == 0)
            $display("grid_astar_next_step_top verification clean");
        else
            $display("grid_astar_next_step_top verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/gastar_pkg.sv
rtl/core/grid_astar_next_step_top.sv
rtl/core/grid_astar_next_step_top_chk.sv
tb/tb.sv
